### design/assert_macros.svh
// Assertion macros shared by the cache RTL; they sample on clock and disable on reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/lkv_pkg.sv
// Package with word types and constants of the LRU key-value cache.
package lkv_pkg;

   localparam int KEY_WIDTH = 32;
   localparam int DATA_WIDTH = 32;
   localparam int CAP_WIDTH = 5;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_SET = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [KEY_WIDTH-1:0]  key;
      logic [DATA_WIDTH-1:0] data_in;
   } req_word_type;

   typedef struct packed {
      logic                  hit;
      logic [DATA_WIDTH-1:0] data_out;
      logic                  evicted;
      logic [KEY_WIDTH-1:0]  evicted_key;
   } rsp_word_type;

endpackage

### design/lkv_chan_if.sv
// Valid/ready channel interface carrying one word per handshake.
interface lkv_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/lkv_store.sv
// Entry store with associative lookup, LRU rank update and insert/evict logic.
`include "assert_macros.svh"

module lkv_store #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  lkv_pkg::req_word_type         word,
   input  logic [lkv_pkg::CAP_WIDTH-1:0] capacity,
   output lkv_pkg::rsp_word_type         result
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > lkv_pkg::CAP_WIDTH) ? CNT_W : lkv_pkg::CAP_WIDTH;

   logic [ENTRIES-1:0]                 valid_ff, valid_in;
   logic [IDX_W-1:0]                   rank_ff [ENTRIES];
   logic [IDX_W-1:0]                   rank_in [ENTRIES];
   logic [lkv_pkg::KEY_WIDTH-1:0]      key_ff [ENTRIES];
   logic [lkv_pkg::KEY_WIDTH-1:0]      key_in [ENTRIES];
   logic [lkv_pkg::DATA_WIDTH-1:0]     value_ff [ENTRIES];
   logic [lkv_pkg::DATA_WIDTH-1:0]     value_in [ENTRIES];
   logic [CNT_W-1:0]                   used_ff, used_in;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] victim_match;
   logic [IDX_W-1:0]   hit_idx, victim_idx, free_idx, slot;
   logic               hit_any, full, update, is_set;
   logic [CMP_W-1:0]   cap_wide, cap_clamped;
   logic [CNT_W-1:0]   eff_cap;
   logic [IDX_W-1:0]   oldest_rank, hit_rank;

   // clamp capacity to 1 .. ENTRIES
   always_comb begin
      cap_wide = CMP_W'(capacity);
      if (cap_wide == '0) begin
         cap_clamped = CMP_W'(1);
      end else if (cap_wide > CMP_W'(ENTRIES)) begin
         cap_clamped = CMP_W'(ENTRIES);
      end else begin
         cap_clamped = cap_wide;
      end
      eff_cap = cap_clamped[CNT_W-1:0];
   end

   // lookup, victim and free slot search
   always_comb begin
      oldest_rank = IDX_W'(used_ff - CNT_W'(1));
      hit_idx = '0;
      victim_idx = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == word.key);
         victim_match[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (victim_match[i]) begin
            victim_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      hit_any = |match;
      hit_rank = rank_ff[hit_idx];
      full = (used_ff >= eff_cap);
      is_set = (word.action == lkv_pkg::ACTION_SET);
      update = fire && (hit_any || is_set);
      if (hit_any) begin
         slot = hit_idx;
      end else if (full) begin
         slot = victim_idx;
      end else begin
         slot = free_idx;
      end
   end

   // next state of every entry
   always_comb begin
      used_in = used_ff;
      if (update && !hit_any && !full) begin
         used_in = used_ff + CNT_W'(1);
      end
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i] = rank_ff[i];
         key_in[i] = key_ff[i];
         value_in[i] = value_ff[i];
         if (update) begin
            if (IDX_W'(i) == slot) begin
               rank_in[i] = '0;
               if (!hit_any && !full) begin
                  valid_in[i] = 1'b1;
               end
               if (!hit_any) begin
                  key_in[i] = word.key;
               end
               if (is_set) begin
                  value_in[i] = word.data_in;
               end
            end else if (valid_ff[i] && (!hit_any || rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
      end
   end

   always_comb begin
      result.hit = hit_any;
      result.data_out = (hit_any && !is_set) ? value_ff[hit_idx] : '0;
      result.evicted = !hit_any && is_set && full;
      result.evicted_key = (!hit_any && is_set && full) ? key_ff[victim_idx] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         used_ff <= used_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i] <= key_in[i];
         value_ff[i] <= value_in[i];
      end
   end

   `ASSERT_ALWAYS(a_fill_matches_valid, $countones(valid_ff) == int'(used_ff), "bad fill count")
   `ASSERT_ALWAYS(a_keys_unique, $onehot0(match), "key present in more than one entry")
   `ASSERT_SAME(a_one_oldest, used_ff != '0, $onehot(victim_match), "no single oldest entry")

endmodule

### design/lru_key_value_cache.sv
// A word accepted on req_if is held in the input register, passes through lkv_store into the
// result register and is offered on rsp_if from there; a stall on rsp_if holds both registers.
// Throughput: one word per cycle while rsp_if is ready; lkv_store does the associative compare
// and rank update for all entries combinationally between the input and result registers.
// Reset (synchronous, active high) clears valid marks, ranks, fill count and both pipeline
// valid flags and sets capacity to 16; keys and values are not cleared and need no sweep.
`include "assert_macros.svh"

module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   lkv_chan_if.sink                      req_if,
   lkv_chan_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [lkv_pkg::CAP_WIDTH-1:0] csr_wr_data
);

   logic                          in_valid_ff, in_valid_in;
   lkv_pkg::req_word_type         in_word_ff, in_word_in;
   logic                          out_valid_ff, out_valid_in;
   lkv_pkg::rsp_word_type         out_word_ff, out_word_in;
   logic [lkv_pkg::CAP_WIDTH-1:0] capacity_ff, capacity_in;
   lkv_pkg::rsp_word_type         result;
   logic                          advance, fire, take;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign fire = in_valid_ff && advance;
   assign take = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   lkv_store #(
      .ENTRIES(ENTRIES)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .word(in_word_ff),
      .capacity(capacity_ff),
      .result(result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in = out_word_ff;
      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_word_in = result;
      end
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
      if (take) begin
         in_word_in = req_if.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         capacity_ff <= lkv_pkg::CAP_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         capacity_ff <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.payload = out_word_ff;

   `ASSERT_NEXT(a_hold_input, in_valid_ff && !advance, $stable(in_word_ff), "input word changed")
   `ASSERT_NEXT(a_fire_yields_result, fire, out_valid_ff, "processed word produced no result")

endmodule

### tb/lru_key_value_cache_tb.sv
// Testbench for the LRU key-value cache: directed and random traffic checked against a predictor.
module lru_key_value_cache_tb;

   localparam int ENTRIES = 16;
   localparam int KEY_POOL_SIZE = 24;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [lkv_pkg::CAP_WIDTH-1:0] csr_wr_data;

   lkv_chan_if #(.payload_type(lkv_pkg::req_word_type)) req_if ();
   lkv_chan_if #(.payload_type(lkv_pkg::rsp_word_type)) rsp_if ();

   lru_key_value_cache #(.ENTRIES(ENTRIES)) uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   logic                           cache_valid [ENTRIES];
   logic [lkv_pkg::KEY_WIDTH-1:0]  cache_key [ENTRIES];
   logic [lkv_pkg::DATA_WIDTH-1:0] cache_value [ENTRIES];
   int unsigned                    cache_rank [ENTRIES];
   int unsigned                    cache_fill;
   logic [lkv_pkg::CAP_WIDTH-1:0]  capacity_setting;

   lkv_pkg::rsp_word_type          pending_rsp_q [$];
   lkv_pkg::rsp_word_type          due_rsp;
   lkv_pkg::rsp_word_type          seen_rsp;
   logic [lkv_pkg::KEY_WIDTH-1:0]  key_pool [KEY_POOL_SIZE];
   logic [lkv_pkg::KEY_WIDTH-1:0]  last_key;
   int                             idle_pct;
   int                             stall_pct;
   int                             fail_count = 0;

   always #2 clock = ~clock;

   function automatic void make_most_recent(input int unsigned slot, input int unsigned limit);
      int unsigned i;
      for (i = 0; i < ENTRIES; i++) begin
         if (cache_valid[i] && i != slot && cache_rank[i] < limit) begin
            cache_rank[i]++;
         end
      end
      cache_rank[slot] = 0;
   endfunction

   function automatic lkv_pkg::rsp_word_type predict_access(input lkv_pkg::req_word_type w);
      lkv_pkg::rsp_word_type r;
      int unsigned i;
      int unsigned slot;
      int unsigned eff_capacity;
      int unsigned oldest_rank;
      logic found;
      r = '0;
      found = 1'b0;
      slot = 0;
      oldest_rank = 0;
      for (i = 0; i < ENTRIES; i++) begin
         if (!found && cache_valid[i] && cache_key[i] == w.key) begin
            found = 1'b1;
            slot = i;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         if (w.action == lkv_pkg::ACTION_GET) begin
            r.data_out = cache_value[slot];
         end else begin
            cache_value[slot] = w.data_in;
         end
         make_most_recent(slot, cache_rank[slot]);
      end else if (w.action == lkv_pkg::ACTION_SET) begin
         eff_capacity = (capacity_setting == 0) ? 1 : capacity_setting;
         if (eff_capacity > ENTRIES) begin
            eff_capacity = ENTRIES;
         end
         if (cache_fill >= eff_capacity) begin
            for (i = 0; i < ENTRIES; i++) begin
               if (cache_valid[i] && (!found || cache_rank[i] > oldest_rank)) begin
                  found = 1'b1;
                  slot = i;
                  oldest_rank = cache_rank[i];
               end
            end
            if (found) begin
               r.evicted = 1'b1;
               r.evicted_key = cache_key[slot];
               cache_key[slot] = w.key;
               cache_value[slot] = w.data_in;
               make_most_recent(slot, oldest_rank);
            end
         end else begin
            for (i = 0; i < ENTRIES; i++) begin
               if (!found && !cache_valid[i]) begin
                  found = 1'b1;
                  slot = i;
               end
            end
            if (found) begin
               make_most_recent(slot, ENTRIES);
               cache_valid[slot] = 1'b1;
               cache_key[slot] = w.key;
               cache_value[slot] = w.data_in;
               cache_fill++;
            end
         end
      end
      return r;
   endfunction

   task automatic send_word(input logic action, input logic [lkv_pkg::KEY_WIDTH-1:0] key,
                            input logic [lkv_pkg::DATA_WIDTH-1:0] data);
      lkv_pkg::req_word_type w;
      w.action = action;
      w.key = key;
      w.data_in = data;
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= w;
      do @(posedge clock); while (!req_if.ready);
      pending_rsp_q.push_back(predict_access(w));
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [lkv_pkg::CAP_WIDTH-1:0] value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      capacity_setting = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_basic_access();
      idle_pct = 0;
      stall_pct = 0;
      write_capacity(5'd2);
      send_word(lkv_pkg::ACTION_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(lkv_pkg::ACTION_SET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(lkv_pkg::ACTION_SET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(lkv_pkg::ACTION_GET, 32'h0000_0000, 32'h0000_0000);
      send_word(lkv_pkg::ACTION_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(lkv_pkg::ACTION_SET, 32'h0000_0000, 32'h1234_5678);
      send_word(lkv_pkg::ACTION_GET, 32'h0000_0000, 32'h0000_0000);
      send_word(lkv_pkg::ACTION_SET, 32'h0000_0001, 32'hA5A5_A5A5);
      send_word(lkv_pkg::ACTION_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(lkv_pkg::ACTION_GET, 32'h0000_0001, 32'h0000_0000);
   endtask

   task automatic test_capacity_limits();
      write_capacity(5'd0);
      send_word(lkv_pkg::ACTION_SET, 32'h0000_0007, 32'h7777_7777);
      send_word(lkv_pkg::ACTION_GET, 32'h0000_0001, 32'h0000_0000);
      send_word(lkv_pkg::ACTION_SET, 32'h0000_0008, 32'h8888_8888);
      send_word(lkv_pkg::ACTION_GET, 32'h0000_0007, 32'h0000_0000);
      write_capacity(5'd31);
      send_word(lkv_pkg::ACTION_SET, 32'h8000_0000, 32'h5A5A_5A5A);
      send_word(lkv_pkg::ACTION_SET, 32'h7FFF_FFFF, 32'hC3C3_C3C3);
      send_word(lkv_pkg::ACTION_SET, 32'h0000_0008, 32'h0F0F_0F0F);
      send_word(lkv_pkg::ACTION_GET, 32'h0000_0008, 32'h0000_0000);
      send_word(lkv_pkg::ACTION_GET, 32'h8000_0000, 32'h0000_0000);
   endtask

   task automatic test_random_traffic(input logic [lkv_pkg::CAP_WIDTH-1:0] cap,
                                      input int sender_idle, input int receiver_stall,
                                      input int count);
      int k;
      int pick;
      logic [lkv_pkg::KEY_WIDTH-1:0] key;
      write_capacity(cap);
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
         end else if (pick < 80) begin
            key = last_key;
         end else if (pick < 92) begin
            key = $urandom;
         end else if (pick < 96) begin
            key = 32'h0000_0000;
         end else begin
            key = 32'hFFFF_FFFF;
         end
         send_word(1'($urandom_range(1)), key, $urandom);
         last_key = key;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            seen_rsp = rsp_if.payload;
            if (pending_rsp_q.size() == 0) begin
               $error("result word with none expected: %h", seen_rsp);
               fail_count++;
            end else begin
               due_rsp = pending_rsp_q.pop_front();
               if (seen_rsp.hit !== due_rsp.hit) begin
                  $error("hit: expected %0d, got %0d", due_rsp.hit, seen_rsp.hit);
                  fail_count++;
               end
               if (seen_rsp.data_out !== due_rsp.data_out) begin
                  $error("data_out: expected %h, got %h", due_rsp.data_out, seen_rsp.data_out);
                  fail_count++;
               end
               if (seen_rsp.evicted !== due_rsp.evicted) begin
                  $error("evicted: expected %0d, got %0d", due_rsp.evicted, seen_rsp.evicted);
                  fail_count++;
               end
               if (seen_rsp.evicted_key !== due_rsp.evicted_key) begin
                  $error("evicted_key: expected %h, got %h",
                         due_rsp.evicted_key, seen_rsp.evicted_key);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int i;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      idle_pct = 0;
      stall_pct = 0;
      last_key = '0;
      cache_fill = 0;
      capacity_setting = lkv_pkg::CAP_RESET;
      for (i = 0; i < ENTRIES; i++) begin
         cache_valid[i] = 1'b0;
         cache_key[i] = '0;
         cache_value[i] = '0;
         cache_rank[i] = 0;
      end
      for (i = 0; i < KEY_POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_access();
      test_capacity_limits();
      test_random_traffic(5'd5, 0, 0, 150);
      test_random_traffic(5'd16, 77, 0, 150);
      test_random_traffic(5'd1, 0, 77, 150);
      test_random_traffic(5'd31, 20, 20, 150);
      test_random_traffic(5'd0, 0, 0, 150);
      test_random_traffic(5'd12, 77, 0, 150);
      test_random_traffic(5'd9, 0, 77, 150);
      test_random_traffic(5'd16, 20, 20, 150);

      drain_results();
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/lkv_pkg.sv
design/lkv_chan_if.sv
design/lkv_store.sv
design/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
